[hdl/cte_pkg.sv]
`timescale 1ns / 1ps
package cte_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HMS_W    = 7;
  localparam int SECS_W   = 39;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // reciprocal division: floor(y/d) = (y * ceil(2^24/d)) >> 24, exact for 14-bit y
  localparam int RECIP_SHIFT = 24;
  localparam int P100_W      = 32;
  localparam int P400_W      = 30;
  localparam logic [17:0] DIV100_MUL = 18'd167773;
  localparam logic [15:0] DIV400_MUL = 16'd41944;
  localparam int Q100_W = P100_W - RECIP_SHIFT;
  localparam int Q400_W = P400_W - RECIP_SHIFT;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;
  localparam int LEAPS_W = 13;
  localparam int YDAYS_W = 23;
  localparam logic [YDAYS_W-1:0] LEAPS_1969 = 23'd477;

  localparam int MDAYS_W = 9;
  localparam int DAYS_W  = 25;
  localparam int TOD_W   = 19;
  localparam int PROD_W  = 43;

  localparam logic signed [PROD_W-1:0] DAY_SECS = 43'sd86400;
  localparam logic signed [PROD_W-1:0] SECS_MAX = 43'sd274877906943;

  typedef struct packed {
    logic               fields_valid;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HMS_W-1:0]   hour;
    logic [HMS_W-1:0]   minute;
    logic [HMS_W-1:0]   second;
  } civil_t;

  typedef struct packed {
    civil_t             civ;
    logic [Q100_W-1:0]  q100;
    logic [Q400_W-1:0]  q400;
  } yq_t;

  typedef struct packed {
    civil_t             civ;
    logic               leap;
    logic [YDAYS_W-1:0] ydays;
  } yd_t;

  typedef struct packed {
    logic                     fields_valid;
    logic signed [DAYS_W-1:0] days;
    logic [TOD_W-1:0]         tod;
  } dd_t;

  // days in the months before month m; anything past December counts the whole year
  function automatic logic [MDAYS_W-1:0] month_days_before(input logic [MONTH_W-1:0] m);
    logic [MDAYS_W-1:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

[hdl/civil_time_to_epoch_seconds.sv]
`timescale 1ns / 1ps
// An accepted input beat moves through every stage to the result beat on the master side.
// One beat per cycle while m_tready is high; the five register stages each hold one item.
// Each stage loads when it is empty or the next stage moves, so a stall holds every item.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
module civil_time_to_epoch_seconds (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [13:0] year, [17:14] month, [22:18] day, [29:23] hour, [36:30] minute,
  // [43:37] second, [47:44] zero
  input  logic [cte_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] fields_valid
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [38:0] epoch_seconds (two's complement), [39] zero
  output logic [cte_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import cte_pkg::*;

  // Stage map:
  //   1  year / 100 and year / 400 by reciprocal multiply
  //   2  leap flag, days of the whole years since 1970
  //   3  month and day added, time of day in seconds
  //   4  days times 86400
  //   5  time of day added, clamp to the field range, -1 for unparsed fields
  localparam int NSTG = 5;

  logic [NSTG-1:0]   vld;
  logic [NSTG-1:0]   en;
  civil_t            civ;
  yd_t               yd;
  dd_t               dd;
  logic [SECS_W-1:0] epoch_seconds;

  assign civ.fields_valid = s_tuser;
  assign civ.year         = s_tdata[13:0];
  assign civ.month        = s_tdata[17:14];
  assign civ.day          = s_tdata[22:18];
  assign civ.hour         = s_tdata[29:23];
  assign civ.minute       = s_tdata[36:30];
  assign civ.second       = s_tdata[43:37];

  // ready ripples back: a stage takes a new beat if empty or if its beat moves on
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int i = NSTG-2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = {1'b0, epoch_seconds};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  cte_year_unit u_year (
    .clk    (clk),
    .en     (en[1:0]),
    .in_civ (civ),
    .out_yd (yd)
  );

  cte_day_unit u_day (
    .clk    (clk),
    .en     (en[2]),
    .in_yd  (yd),
    .out_dd (dd)
  );

  cte_secs_unit u_secs (
    .clk           (clk),
    .en            (en[4:3]),
    .in_dd         (dd),
    .epoch_seconds (epoch_seconds)
  );

endmodule

[hdl/cte_year_unit.sv]
`timescale 1ns / 1ps
module cte_year_unit (
  input  logic            clk,
  input  logic [1:0]      en,
  input  cte_pkg::civil_t in_civ,
  output cte_pkg::yd_t    out_yd
);
  import cte_pkg::*;

  yq_t                s1;
  logic [P100_W-1:0]  p100;
  logic [P400_W-1:0]  p400;
  logic [YEAR_W-1:0]  y100;
  logic [YEAR_W-1:0]  y400;
  logic [YEAR_W-1:0]  ym1;
  logic               c100;
  logic               c400;
  logic               leap_next;
  logic [LEAPS_W-1:0] leaps_prev;
  logic [YDAYS_W-1:0] ydays_next;

  // stage 1: quotients by 100 and 400
  assign p100 = P100_W'(in_civ.year) * P100_W'(DIV100_MUL);
  assign p400 = P400_W'(in_civ.year) * P400_W'(DIV400_MUL);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1.civ  <= in_civ;
      s1.q100 <= p100[P100_W-1:RECIP_SHIFT];
      s1.q400 <= p400[P400_W-1:RECIP_SHIFT];
    end
  end

  // stage 2: leap flag and whole-year days
  always_comb begin
    y100      = YEAR_W'(s1.q100) * 14'd100;
    y400      = YEAR_W'(s1.q400) * 14'd400;
    c100      = (y100 == s1.civ.year);
    c400      = (y400 == s1.civ.year);
    leap_next = (s1.civ.year[1:0] == 2'b00) && (!c100 || c400);
    // leaps in 1..year-1, from the quotients of year itself
    ym1        = s1.civ.year - 14'd1;
    leaps_prev = LEAPS_W'(ym1[YEAR_W-1:2]) - LEAPS_W'(s1.q100) + LEAPS_W'(c100)
               + LEAPS_W'(s1.q400) - LEAPS_W'(c400);
    if (s1.civ.year > EPOCH_YEAR) begin
      ydays_next = YDAYS_W'(s1.civ.year - EPOCH_YEAR) * 23'd365
                 + YDAYS_W'(leaps_prev) - LEAPS_1969;
    end else begin
      ydays_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_yd.civ   <= s1.civ;
      out_yd.leap  <= leap_next;
      out_yd.ydays <= ydays_next;
    end
  end

endmodule

[hdl/cte_day_unit.sv]
`timescale 1ns / 1ps
module cte_day_unit (
  input  logic         clk,
  input  logic         en,
  input  cte_pkg::yd_t in_yd,
  output cte_pkg::dd_t out_dd
);
  import cte_pkg::*;

  logic [MDAYS_W-1:0]      mdays;
  logic signed [DAYS_W-1:0] days_next;
  logic [TOD_W-1:0]        tod_next;

  always_comb begin
    mdays = month_days_before(in_yd.civ.month)
          + MDAYS_W'(in_yd.leap && (in_yd.civ.month >= 4'd3));
    days_next = $signed(DAYS_W'(in_yd.ydays)) + $signed(DAYS_W'(mdays))
              + $signed(DAYS_W'(in_yd.civ.day)) - 25'sd1;
    tod_next = TOD_W'(in_yd.civ.hour) * 19'd3600 + TOD_W'(in_yd.civ.minute) * 19'd60
             + TOD_W'(in_yd.civ.second);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dd.fields_valid <= in_yd.civ.fields_valid;
      out_dd.days         <= days_next;
      out_dd.tod          <= tod_next;
    end
  end

endmodule

[hdl/cte_secs_unit.sv]
`timescale 1ns / 1ps
module cte_secs_unit (
  input  logic              clk,
  input  logic [1:0]        en,
  input  cte_pkg::dd_t      in_dd,
  output logic [cte_pkg::SECS_W-1:0] epoch_seconds
);
  import cte_pkg::*;

  logic                     fv4;
  logic signed [PROD_W-1:0] prod;
  logic [TOD_W-1:0]         tod4;
  logic signed [PROD_W-1:0] sum;
  logic [SECS_W-1:0]        secs_next;

  // stage 4: days to seconds
  always_ff @(posedge clk) begin
    if (en[0]) begin
      fv4  <= in_dd.fields_valid;
      prod <= PROD_W'(in_dd.days) * DAY_SECS;
      tod4 <= in_dd.tod;
    end
  end

  // stage 5: time of day, clamp, invalid marker
  always_comb begin
    sum = prod + $signed(PROD_W'(tod4));
    if (!fv4) begin
      secs_next = '1;
    end else if (sum > SECS_MAX) begin
      secs_next = SECS_MAX[SECS_W-1:0];
    end else begin
      secs_next = sum[SECS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      epoch_seconds <= secs_next;
    end
  end

endmodule
